>>> hw/rtl/cbf_pkg.sv
// Shared types and constants of the cubic Bezier flattener.
package cbf_pkg;

   // Field widths fixed by the interface
   localparam int COORD_W = 16;
   localparam int THR_W   = 15;
   localparam int LEVEL_W = 3;
   localparam int WORD_W  = 32;
   // headroom for the de Casteljau sums before they wrap back to 32 bits
   localparam int EXT_W   = WORD_W + 3;
   localparam int N_WORDS = 8;

   // Defaults for the top level parameters
   localparam int MAX_DEPTH_DEF = 5;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WORD_W-1:0]  word_type;

   // index 2*j+k holds control point j, axis k (0 = x, 1 = y)
   typedef word_type [N_WORDS-1:0] curve_type;

   typedef struct packed {
      coord_type p0_x;
      coord_type p0_y;
      coord_type p1_x;
      coord_type p1_y;
      coord_type p2_x;
      coord_type p2_y;
      coord_type p3_x;
      coord_type p3_y;
   } req_payload_type;

   typedef struct packed {
      coord_type out_x;
      coord_type out_y;
      logic      last_point;
      logic      depth_capped;
   } rsp_payload_type;

   // One pending right half and its subdivision level
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      curve_type          curve;
   } stack_row_type;

   // Access request to the pending stack
   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [LEVEL_W-1:0] addr;
   } stack_ctl_type;

endpackage

>>> hw/rtl/cbf_split.sv
// De Casteljau split of one cubic subcurve into its left and right halves.
module cbf_split (
   input  cbf_pkg::curve_type cur,
   output cbf_pkg::curve_type left_half,
   output cbf_pkg::curve_type right_half
);
   import cbf_pkg::*;

   // Same arithmetic on both axes; all shifts truncate toward minus infinity
   for (genvar k = 0; k < 2; k++) begin : g_axis
      logic signed [EXT_W-1:0] a, b, d, e;
      logic signed [EXT_W-1:0] b8, d8, mid;
      logic signed [EXT_W-1:0] l1, l2, r1, r2;

      assign a  = EXT_W'($signed(cur[k]));
      assign b  = EXT_W'($signed(cur[2+k]));
      assign d  = EXT_W'($signed(cur[4+k]));
      assign e  = EXT_W'($signed(cur[6+k]));
      assign b8 = b >>> 3;
      assign d8 = d >>> 3;

      assign mid = (a >>> 3) + (b8 <<< 1) + b8 + (d8 <<< 1) + d8 + (e >>> 3);
      assign l1  = (a >>> 1) + (b >>> 1);
      assign l2  = (a >>> 2) + (b >>> 1) + (d >>> 2);
      assign r1  = (e >>> 2) + (d >>> 1) + (b >>> 2);
      assign r2  = (e >>> 1) + (d >>> 1);

      // results wrap to 32 bits like the stored words
      assign left_half[k]    = cur[k];
      assign left_half[2+k]  = l1[WORD_W-1:0];
      assign left_half[4+k]  = l2[WORD_W-1:0];
      assign left_half[6+k]  = mid[WORD_W-1:0];
      assign right_half[k]   = mid[WORD_W-1:0];
      assign right_half[2+k] = r1[WORD_W-1:0];
      assign right_half[4+k] = r2[WORD_W-1:0];
      assign right_half[6+k] = cur[6+k];
   end

endmodule

>>> hw/rtl/cbf_stack.sv
// Pending-half stack: one synchronous memory row per subdivision level.
module cbf_stack #(
   parameter int MAX_DEPTH = cbf_pkg::MAX_DEPTH_DEF
) (
   input  logic                   clock,
   input  cbf_pkg::stack_ctl_type ctl,
   input  cbf_pkg::stack_row_type wr_row,
   output cbf_pkg::stack_row_type rd_row
);
   import cbf_pkg::*;

   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   stack_row_type         mem [MAX_DEPTH];
   stack_row_type         rd_row_ff;
   logic [IDX_W-1:0]      idx;

   assign idx = ctl.addr[IDX_W-1:0];

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[idx] <= wr_row;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_row_ff <= mem[idx];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

>>> hw/rtl/cubic_bezier_flattener.sv
// Top level of the cubic Bezier flattener: control sequencer and output register.
//
// Usage:
//  - req_*: one cubic curve per transfer, four signed 16-bit control points.
//  - rsp_*: polyline vertices. The start point comes first, then the rounded
//    end point of every flat subcurve in depth-first order; last_point marks
//    the final vertex, depth_capped marks a leaf forced flat by the depth limit.
//  - csr_*: flat_threshold in whole pixels, written whenever csr_wr_en is high.
// Timing:
//  - The start point is on rsp in the cycle after the request transfer.
//  - Each visited subcurve passes a bounding box step, then a test and split
//    or emit step; each pop from the stack memory adds a read step.
//  - One curve is in flight at a time; req_ready rises again once the
//    sequencer is idle and the output register can take the next start point.
// Reset: synchronous, clears the sequencer, stack pointer and output valid,
// and sets flat_threshold to 2. The stack memory needs no clearing.
// Stall: a leaf waits while the output register is full and rsp_ready is low.
module cubic_bezier_flattener #(
   parameter int MAX_DEPTH = cbf_pkg::MAX_DEPTH_DEF,
   parameter int FRAC_BITS = cbf_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cbf_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output cbf_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_wr_en,
   input  logic [cbf_pkg::THR_W-1:0] csr_wr_data
);
   import cbf_pkg::*;

   localparam int SPAN_W = WORD_W + 1;
   localparam int RND_W  = WORD_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_MEASURE = 4'b0010,
      ST_EVAL    = 4'b0100,
      ST_POP     = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   curve_type          curve_ff, curve_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [LEVEL_W-1:0] sp_ff, sp_in;
   word_type           min_x_ff, min_x_in, max_x_ff, max_x_in;
   word_type           min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   curve_type          left_half, right_half;
   stack_ctl_type      stack_ctl;
   stack_row_type      stack_wr_row, stack_rd_row;

   logic               slot_free;
   logic               req_xfer;
   logic [SPAN_W-1:0]  span_x, span_y, thr_fix;
   logic               box_flat, leaf;

   function automatic word_type min2(word_type a, word_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic word_type max2(word_type a, word_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic word_type scale_in(coord_type c);
      return WORD_W'($signed(c)) <<< FRAC_BITS;
   endfunction

   // round half up from fixed point, then saturate to 16 bits
   function automatic coord_type round_sat(word_type v);
      logic signed [RND_W-1:0] sum;
      logic signed [RND_W-1:0] q;
      coord_type               r;
      sum = RND_W'(v) + (RND_W'(1) <<< (FRAC_BITS - 1));
      q   = sum >>> FRAC_BITS;
      if (q > RND_W'(32767)) begin
         r = coord_type'(16'sh7FFF);
      end else if (q < -RND_W'(32768)) begin
         r = coord_type'(16'sh8000);
      end else begin
         r = q[COORD_W-1:0];
      end
      return r;
   endfunction

   cbf_split u_split (
      .cur        (curve_ff),
      .left_half  (left_half),
      .right_half (right_half)
   );

   cbf_stack #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock  (clock),
      .ctl    (stack_ctl),
      .wr_row (stack_wr_row),
      .rd_row (stack_rd_row)
   );

   // handshake
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // flatness test on the registered bounding box
   assign span_x   = SPAN_W'($signed(max_x_ff)) - SPAN_W'($signed(min_x_ff));
   assign span_y   = SPAN_W'($signed(max_y_ff)) - SPAN_W'($signed(min_y_ff));
   assign thr_fix  = SPAN_W'(thr_ff) << FRAC_BITS;
   assign box_flat = (span_x < thr_fix) || (span_y < thr_fix);
   assign leaf     = box_flat || (level_ff >= LEVEL_W'(MAX_DEPTH));

   assign stack_wr_row.level = LEVEL_W'(level_ff + 1'b1);
   assign stack_wr_row.curve = right_half;

   // threshold register
   always_comb begin
      thr_in = csr_wr_en ? csr_wr_data : thr_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      curve_in     = curve_ff;
      level_in     = level_ff;
      sp_in        = sp_ff;
      min_x_in     = min_x_ff;
      max_x_in     = max_x_ff;
      min_y_in     = min_y_ff;
      max_y_in     = max_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      stack_ctl    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               curve_in[0] = scale_in(req_data.p0_x);
               curve_in[1] = scale_in(req_data.p0_y);
               curve_in[2] = scale_in(req_data.p1_x);
               curve_in[3] = scale_in(req_data.p1_y);
               curve_in[4] = scale_in(req_data.p2_x);
               curve_in[5] = scale_in(req_data.p2_y);
               curve_in[6] = scale_in(req_data.p3_x);
               curve_in[7] = scale_in(req_data.p3_y);
               level_in    = '0;
               sp_in       = '0;
               rsp_valid_in             = 1'b1;
               rsp_data_in.out_x        = req_data.p0_x;
               rsp_data_in.out_y        = req_data.p0_y;
               rsp_data_in.last_point   = 1'b0;
               rsp_data_in.depth_capped = 1'b0;
               state_in    = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            min_x_in = min2(min2(curve_ff[0], curve_ff[2]), min2(curve_ff[4], curve_ff[6]));
            max_x_in = max2(max2(curve_ff[0], curve_ff[2]), max2(curve_ff[4], curve_ff[6]));
            min_y_in = min2(min2(curve_ff[1], curve_ff[3]), min2(curve_ff[5], curve_ff[7]));
            max_y_in = max2(max2(curve_ff[1], curve_ff[3]), max2(curve_ff[5], curve_ff[7]));
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (leaf) begin
               // emit the end point once the output register can take it
               if (slot_free) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.out_x        = round_sat(curve_ff[6]);
                  rsp_data_in.out_y        = round_sat(curve_ff[7]);
                  rsp_data_in.last_point   = (sp_ff == '0);
                  rsp_data_in.depth_capped = !box_flat;
                  if (sp_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     sp_in           = LEVEL_W'(sp_ff - 1'b1);
                     stack_ctl.rd_en = 1'b1;
                     stack_ctl.addr  = LEVEL_W'(sp_ff - 1'b1);
                     state_in        = ST_POP;
                  end
               end
            end else begin
               // push the right half, continue on the left half
               stack_ctl.wr_en = 1'b1;
               stack_ctl.addr  = sp_ff;
               sp_in           = LEVEL_W'(sp_ff + 1'b1);
               level_in        = LEVEL_W'(level_ff + 1'b1);
               curve_in        = left_half;
               state_in        = ST_MEASURE;
            end
         end
         ST_POP: begin
            curve_in = stack_rd_row.curve;
            level_in = stack_rd_row.level;
            state_in = ST_MEASURE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         sp_ff        <= '0;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         sp_ff        <= sp_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      curve_ff    <= curve_in;
      min_x_ff    <= min_x_in;
      max_x_ff    <= max_x_in;
      min_y_ff    <= min_y_in;
      max_y_ff    <= max_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   // stack never holds more halves than levels
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= LEVEL_W'(MAX_DEPTH))
      else $error("stack pointer beyond depth limit");

   // depth of the subcurve in work never passes the limit
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LEVEL_W'(MAX_DEPTH))
      else $error("subdivision level beyond depth limit");

   // a pop always loads data read in the previous cycle
   a_pop_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> $past(stack_ctl.rd_en))
      else $error("pop without stack read");

   // a push never overlaps a pop on the stack memory
   a_stack_port: assert property (@(posedge clock) disable iff (reset)
      !(stack_ctl.wr_en && stack_ctl.rd_en))
      else $error("stack read and write in one cycle");

   // the final vertex of a curve leaves the sequencer idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && leaf && slot_free && sp_ff == '0) |=>
         (state_ff == ST_IDLE && rsp_valid_ff && rsp_data_ff.last_point))
      else $error("last vertex without return to idle");

endmodule
